@@ rtl/i2cbm_pkg.sv @@
// Shared types, codes and reset values of the I2C bit-level master.
// Depends on nothing; every module of the block imports it.
package i2cbm_pkg;

  localparam int DELAY_WIDTH_DEF   = 10;
  localparam int TIMEOUT_WIDTH_DEF = 16;
  localparam int CFG_DATA_W        = 16;
  localparam int CFG_INDEX_W       = 3;

  // Sequencer steps resolved in one tick; the longest chain of
  // non-waiting phases is four.
  localparam int SEQ_STEPS = 4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HOLD      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_RISE_FALL = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_BIT_TMO   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_BYTE_TMO  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_ACK_TMO   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_START_TMO = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_NACK    = 2'd2;

  // Address patterns that need a second address byte
  localparam logic [7:0] ADDR_TEN_MASK   = 8'hF8;
  localparam logic [7:0] ADDR_TEN_PREFIX = 8'hF0;
  localparam logic [7:0] ADDR_GC_MASK    = 8'hFE;
  localparam logic [7:0] ADDR_GC_PREFIX  = 8'h00;

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_WRITE = 3'd3,
    ACT_READ  = 3'd4,
    ACT_ADDR  = 3'd5
  } act_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_S_BEGIN, PH_S_AFTER, PH_S_LOW, PH_S_END,
    PH_T_BEGIN, PH_T_2, PH_T_3, PH_T_END,
    PH_W_BEGIN, PH_W_AFTER, PH_W_LOW, PH_RAISE_SET, PH_RAISE_POLL,
    PH_B_BEGIN, PH_B_BIT_DONE, PH_B_ACK_RAISE, PH_B_ACK_RAISED, PH_B_ACK_POLL,
    PH_B_ACK_SAMPLE, PH_B_ACK_END, PH_B_DONE,
    PH_R_BEGIN, PH_R_BIT, PH_R_RAISED, PH_R_SAMPLE, PH_R_BIT_DONE, PH_R_ACK_DONE
  } phase_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  data_byte;
    logic        final_read;
    logic [15:0] bus_address;
    logic        scl_in;
    logic        sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
  } out_word_t;

  typedef struct packed {
    logic [9:0]  hold_time;
    logic [9:0]  rise_fall_time;
    logic [15:0] bit_timeout;
    logic [15:0] byte_timeout;
    logic [15:0] ack_timeout;
    logic [15:0] start_timeout;
  } cfg_t;

  // Sequencer state without the parameter-sized counters
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift_byte;
    logic [7:0]  rd_byte;
    logic [15:0] addr_latch;
    act_t        kind;
    logic        scl_drive;
    logic        sda_drive;
    logic [1:0]  last_status;
    phase_t      raise_ret;
    phase_t      bit_ret;
    logic [1:0]  pend;
    logic        raise_ok;
    logic        second_byte;
    logic        nack_last;
    logic        done_pulse;
    logic        waiting;
  } seq_t;

  localparam cfg_t CFG_RESET = '{
    hold_time:      10'd5,
    rise_fall_time: 10'd2,
    bit_timeout:    16'd5,
    byte_timeout:   16'd5,
    ack_timeout:    16'd5,
    start_timeout:  16'd5
  };

  localparam seq_t SEQ_RESET = '{
    phase:       PH_IDLE,
    bit_count:   4'd0,
    shift_byte:  8'd0,
    rd_byte:     8'd0,
    addr_latch:  16'd0,
    kind:        ACT_TICK,
    scl_drive:   1'b1,
    sda_drive:   1'b1,
    last_status: ST_OK,
    raise_ret:   PH_IDLE,
    bit_ret:     PH_IDLE,
    pend:        ST_OK,
    raise_ok:    1'b0,
    second_byte: 1'b0,
    nack_last:   1'b0,
    done_pulse:  1'b0,
    waiting:     1'b0
  };

endpackage

@@ rtl/i2cbm_cfg.sv @@
// Configuration registers of the I2C bit-level master: timing and timeouts.
// Depends on i2cbm_pkg.
module i2cbm_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [i2cbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [i2cbm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output i2cbm_pkg::cfg_t                    cfg
);
  import i2cbm_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_HOLD:      cfg_nxt.hold_time      = cfg_wdata[9:0];
        CFG_IDX_RISE_FALL: cfg_nxt.rise_fall_time = cfg_wdata[9:0];
        CFG_IDX_BIT_TMO:   cfg_nxt.bit_timeout    = cfg_wdata;
        CFG_IDX_BYTE_TMO:  cfg_nxt.byte_timeout   = cfg_wdata;
        CFG_IDX_ACK_TMO:   cfg_nxt.ack_timeout    = cfg_wdata;
        CFG_IDX_START_TMO: cfg_nxt.start_timeout  = cfg_wdata;
        default:           cfg_nxt = cfg_r;  // unused index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/i2cbm_step.sv @@
// One sequencer step of the I2C bit-level master: advances the phase once
// unless the chain is already waiting. Depends on i2cbm_pkg.
module i2cbm_step #(
  parameter int DELAY_WIDTH   = i2cbm_pkg::DELAY_WIDTH_DEF,
  parameter int TIMEOUT_WIDTH = i2cbm_pkg::TIMEOUT_WIDTH_DEF,
  parameter int CNT_W = (TIMEOUT_WIDTH > DELAY_WIDTH) ? TIMEOUT_WIDTH : DELAY_WIDTH
) (
  input  i2cbm_pkg::seq_t     seq_in,
  input  logic [DELAY_WIDTH-1:0] dly_in,
  input  logic [CNT_W-1:0]    tmo_in,
  input  logic [DELAY_WIDTH-1:0] ht,
  input  logic [DELAY_WIDTH-1:0] rf,
  input  logic [CNT_W-1:0]    tmo_start,
  input  logic [CNT_W-1:0]    tmo_byte,
  input  logic [CNT_W-1:0]    tmo_bit,
  input  logic [CNT_W-1:0]    tmo_ack,
  input  logic                scl_in,
  input  logic                sda_in,
  output i2cbm_pkg::seq_t     seq_out,
  output logic [DELAY_WIDTH-1:0] dly_out,
  output logic [CNT_W-1:0]    tmo_out
);
  import i2cbm_pkg::*;

  function automatic seq_t finish_f(seq_t s, logic [1:0] st);
    seq_t r;
    r = s;
    r.phase       = PH_IDLE;
    r.last_status = st;
    r.done_pulse  = 1'b1;
    r.waiting     = 1'b1;
    return r;
  endfunction

  // End of a byte: address commands may go on with the high byte or a stop.
  function automatic seq_t byte_res_f(seq_t s, logic [1:0] st);
    seq_t r;
    r = s;
    if (s.kind != ACT_ADDR) begin
      r = finish_f(s, st);
    end else if (st != ST_OK) begin
      r.pend  = st;
      r.phase = PH_T_BEGIN;
    end else if (!s.second_byte) begin
      if (((s.addr_latch[7:0] & ADDR_TEN_MASK) != ADDR_TEN_PREFIX) &&
          ((s.addr_latch[7:0] & ADDR_GC_MASK) != ADDR_GC_PREFIX)) begin
        r = finish_f(s, ST_OK);
      end else begin
        r.second_byte = 1'b1;
        r.shift_byte  = s.addr_latch[15:8];
        r.phase       = PH_B_BEGIN;
      end
    end else begin
      r = finish_f(s, ST_OK);
    end
    return r;
  endfunction

  logic [3:0]       bc_inc;
  logic [2:0]       bit_sel;
  logic [2:0]       rd_sel;
  logic [CNT_W-1:0] ht_w;
  logic [CNT_W-1:0] rf_w;

  assign bc_inc  = seq_in.bit_count + 4'd1;
  assign bit_sel = 3'd7 - bc_inc[2:0];
  assign rd_sel  = 3'd7 - seq_in.bit_count[2:0];
  assign ht_w    = CNT_W'(ht);
  assign rf_w    = CNT_W'(rf);

  always_comb begin
    seq_out = seq_in;
    dly_out = dly_in;
    tmo_out = tmo_in;
    if (!seq_in.waiting) begin
      unique case (seq_in.phase)
        PH_S_BEGIN: begin
          seq_out.sda_drive = 1'b1;
          tmo_out           = tmo_start;
          seq_out.raise_ret = PH_S_AFTER;
          seq_out.phase     = PH_RAISE_SET;
        end
        PH_S_AFTER: begin
          if (!seq_in.raise_ok) begin
            seq_out = finish_f(seq_in, ST_TIMEOUT);
          end else begin
            seq_out.sda_drive = 1'b0;
            seq_out.phase     = PH_S_LOW;
            dly_out           = ht;
            seq_out.waiting   = 1'b1;
          end
        end
        PH_S_LOW: begin
          seq_out.scl_drive = 1'b0;
          seq_out.sda_drive = 1'b0;
          seq_out.phase     = PH_S_END;
          dly_out           = ht;
          seq_out.waiting   = 1'b1;
        end
        PH_S_END: begin
          if (seq_in.kind != ACT_ADDR) begin
            seq_out = finish_f(seq_in, ST_OK);
          end else begin
            seq_out.second_byte = 1'b0;
            seq_out.shift_byte  = seq_in.addr_latch[7:0];
            seq_out.phase       = PH_B_BEGIN;
          end
        end
        PH_T_BEGIN: begin
          seq_out.scl_drive = 1'b0;
          seq_out.sda_drive = 1'b0;
          seq_out.phase     = PH_T_2;
          dly_out           = rf;
          seq_out.waiting   = 1'b1;
        end
        PH_T_2: begin
          seq_out.scl_drive = 1'b1;
          seq_out.phase     = PH_T_3;
          dly_out           = ht;
          seq_out.waiting   = 1'b1;
        end
        PH_T_3: begin
          seq_out.sda_drive = 1'b1;
          seq_out.phase     = PH_T_END;
          dly_out           = ht;
          seq_out.waiting   = 1'b1;
        end
        PH_T_END: begin
          seq_out = finish_f(seq_in, seq_in.pend);
        end
        PH_W_BEGIN: begin
          seq_out.scl_drive = 1'b0;
          seq_out.raise_ret = PH_W_AFTER;
          seq_out.phase     = PH_RAISE_SET;
          dly_out           = rf;
          seq_out.waiting   = 1'b1;
        end
        PH_W_AFTER: begin
          seq_out.phase   = PH_W_LOW;
          dly_out         = ht;
          seq_out.waiting = 1'b1;
        end
        PH_W_LOW: begin
          seq_out.scl_drive = 1'b0;
          seq_out.phase     = seq_in.bit_ret;
          dly_out           = ht;
          seq_out.waiting   = 1'b1;
        end
        PH_RAISE_SET: begin
          seq_out.scl_drive = 1'b1;
          seq_out.phase     = PH_RAISE_POLL;
          dly_out           = rf;
          seq_out.waiting   = 1'b1;
        end
        PH_RAISE_POLL: begin
          if (tmo_in == '0) begin
            seq_out.raise_ok = 1'b0;
            seq_out.phase    = seq_in.raise_ret;
          end else if (scl_in) begin
            seq_out.raise_ok = 1'b1;
            seq_out.phase    = seq_in.raise_ret;
          end else begin
            // Slave still stretches: charge one poll interval and poll again
            tmo_out         = (tmo_in > rf_w) ? tmo_in - rf_w : '0;
            dly_out         = rf;
            seq_out.waiting = 1'b1;
          end
        end
        PH_B_BEGIN: begin
          seq_out.bit_count = 4'd0;
          seq_out.sda_drive = seq_in.shift_byte[7];
          tmo_out           = tmo_byte;
          seq_out.bit_ret   = PH_B_BIT_DONE;
          seq_out.phase     = PH_W_BEGIN;
        end
        PH_B_BIT_DONE: begin
          if (!seq_in.raise_ok) begin
            seq_out = byte_res_f(seq_in, ST_TIMEOUT);
          end else begin
            seq_out.bit_count = bc_inc;
            if (bc_inc < 4'd8) begin
              seq_out.sda_drive = seq_in.shift_byte[bit_sel];
              tmo_out           = tmo_bit;
              seq_out.phase     = PH_W_BEGIN;
            end else begin
              seq_out.scl_drive = 1'b0;
              seq_out.sda_drive = 1'b1;
              seq_out.phase     = PH_B_ACK_RAISE;
              dly_out           = rf;
              seq_out.waiting   = 1'b1;
            end
          end
        end
        PH_B_ACK_RAISE: begin
          tmo_out           = ht_w;
          seq_out.raise_ret = PH_B_ACK_RAISED;
          seq_out.phase     = PH_RAISE_SET;
        end
        PH_B_ACK_RAISED: begin
          if (!seq_in.raise_ok) begin
            seq_out.pend  = ST_TIMEOUT;
            seq_out.phase = PH_B_ACK_END;
          end else begin
            tmo_out       = tmo_ack;
            seq_out.phase = PH_B_ACK_POLL;
          end
        end
        PH_B_ACK_POLL: begin
          if (tmo_in == '0) begin
            seq_out.pend  = ST_NACK;
            seq_out.phase = PH_B_ACK_END;
          end else begin
            seq_out.phase   = PH_B_ACK_SAMPLE;
            dly_out         = ht;
            seq_out.waiting = 1'b1;
          end
        end
        PH_B_ACK_SAMPLE: begin
          if (!sda_in) begin
            seq_out.pend  = ST_OK;
            seq_out.phase = PH_B_ACK_END;
          end else begin
            tmo_out       = (tmo_in > ht_w) ? tmo_in - ht_w : '0;
            seq_out.phase = PH_B_ACK_POLL;
          end
        end
        PH_B_ACK_END: begin
          seq_out.scl_drive = 1'b0;
          seq_out.sda_drive = 1'b1;
          seq_out.phase     = PH_B_DONE;
          dly_out           = ht;
          seq_out.waiting   = 1'b1;
        end
        PH_B_DONE: begin
          seq_out = byte_res_f(seq_in, seq_in.pend);
        end
        PH_R_BEGIN: begin
          seq_out.scl_drive = 1'b0;
          seq_out.sda_drive = 1'b1;
          seq_out.bit_count = 4'd0;
          seq_out.phase     = PH_R_BIT;
          dly_out           = rf;
          seq_out.waiting   = 1'b1;
        end
        PH_R_BIT: begin
          seq_out.sda_drive = 1'b1;
          tmo_out           = (seq_in.bit_count == 4'd0) ? tmo_byte : tmo_bit;
          seq_out.raise_ret = PH_R_RAISED;
          seq_out.phase     = PH_RAISE_SET;
        end
        PH_R_RAISED: begin
          seq_out.phase   = PH_R_SAMPLE;
          dly_out         = ht;
          seq_out.waiting = 1'b1;
        end
        PH_R_SAMPLE: begin
          if (seq_in.raise_ok) begin
            if (seq_in.bit_count == 4'd0) begin
              seq_out.rd_byte = {sda_in, 7'd0};
            end else begin
              seq_out.rd_byte[rd_sel] = seq_in.rd_byte[rd_sel] | sda_in;
            end
          end
          seq_out.scl_drive = 1'b0;
          seq_out.sda_drive = 1'b1;
          seq_out.phase     = PH_R_BIT_DONE;
          dly_out           = ht;
          seq_out.waiting   = 1'b1;
        end
        PH_R_BIT_DONE: begin
          if (!seq_in.raise_ok) begin
            seq_out = finish_f(seq_in, ST_TIMEOUT);
          end else begin
            seq_out.bit_count = bc_inc;
            if (bc_inc < 4'd8) begin
              seq_out.phase = PH_R_BIT;
            end else begin
              seq_out.sda_drive = seq_in.nack_last;
              tmo_out           = tmo_bit;
              seq_out.bit_ret   = PH_R_ACK_DONE;
              seq_out.phase     = PH_W_BEGIN;
            end
          end
        end
        PH_R_ACK_DONE: begin
          seq_out = finish_f(seq_in, seq_in.raise_ok ? ST_OK : ST_TIMEOUT);
        end
        default: begin
          seq_out.phase   = PH_IDLE;
          seq_out.waiting = 1'b1;
        end
      endcase
    end
  end

endmodule

@@ rtl/i2cbm_core.sv @@
// Per-tick state update of the I2C bit-level master: delay countdown,
// command pickup and a short chain of sequencer steps. Depends on i2cbm_pkg.
module i2cbm_core #(
  parameter int DELAY_WIDTH   = i2cbm_pkg::DELAY_WIDTH_DEF,
  parameter int TIMEOUT_WIDTH = i2cbm_pkg::TIMEOUT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tick_en,
  input  i2cbm_pkg::in_word_t  in_word,
  input  i2cbm_pkg::cfg_t      cfg,
  output i2cbm_pkg::out_word_t res
);
  import i2cbm_pkg::*;

  localparam int CNT_W = (TIMEOUT_WIDTH > DELAY_WIDTH) ? TIMEOUT_WIDTH : DELAY_WIDTH;
  localparam logic [15:0] DLY_MASK =
    (DELAY_WIDTH >= 16) ? 16'hFFFF : 16'((17'd1 << DELAY_WIDTH) - 17'd1);
  localparam logic [31:0] TMO_MASK =
    (TIMEOUT_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((33'd1 << TIMEOUT_WIDTH) - 33'd1);

  seq_t                   seq_r, seq_nxt;
  logic [DELAY_WIDTH-1:0] dly_r, dly_nxt;
  logic [CNT_W-1:0]       tmo_r, tmo_nxt;

  seq_t                   seq_init;
  logic [DELAY_WIDTH-1:0] dly_init;

  seq_t                   seq_s [SEQ_STEPS];
  logic [DELAY_WIDTH-1:0] dly_s [SEQ_STEPS];
  logic [CNT_W-1:0]       tmo_s [SEQ_STEPS];

  logic [15:0]            ht_raw, rf_raw;
  logic [DELAY_WIDTH-1:0] ht, rf;
  logic [CNT_W-1:0]       tmo_start, tmo_byte, tmo_bit, tmo_ack;

  // Hold and edge times are masked to the counter width; zero means one tick
  assign ht_raw = {6'd0, cfg.hold_time} & DLY_MASK;
  assign rf_raw = {6'd0, cfg.rise_fall_time} & DLY_MASK;
  assign ht     = (ht_raw == 16'd0) ? DELAY_WIDTH'(1) : DELAY_WIDTH'(ht_raw);
  assign rf     = (rf_raw == 16'd0) ? DELAY_WIDTH'(1) : DELAY_WIDTH'(rf_raw);

  assign tmo_start = CNT_W'({16'd0, cfg.start_timeout} & TMO_MASK);
  assign tmo_byte  = CNT_W'({16'd0, cfg.byte_timeout} & TMO_MASK);
  assign tmo_bit   = CNT_W'({16'd0, cfg.bit_timeout} & TMO_MASK);
  assign tmo_ack   = CNT_W'({16'd0, cfg.ack_timeout} & TMO_MASK);

  always_comb begin
    seq_init            = seq_r;
    seq_init.done_pulse = 1'b0;
    dly_init            = dly_r;
    if (seq_r.phase != PH_IDLE && dly_r != '0) begin
      dly_init = dly_r - DELAY_WIDTH'(1);
    end
    if (seq_r.phase == PH_IDLE) begin
      unique case (act_t'(in_word.action))
        ACT_START, ACT_ADDR: seq_init.phase = PH_S_BEGIN;
        ACT_STOP:            seq_init.phase = PH_T_BEGIN;
        ACT_WRITE:           seq_init.phase = PH_B_BEGIN;
        ACT_READ:            seq_init.phase = PH_R_BEGIN;
        default:             seq_init.phase = PH_IDLE;
      endcase
      if (seq_init.phase != PH_IDLE) begin
        seq_init.kind       = act_t'(in_word.action);
        seq_init.pend       = ST_OK;
        seq_init.shift_byte = in_word.data_byte;
        seq_init.nack_last  = in_word.final_read;
        seq_init.addr_latch = in_word.bus_address;
        dly_init            = '0;
      end
    end
    // Run the chain only when a phase is due this tick
    seq_init.waiting = !(seq_init.phase != PH_IDLE && dly_init == '0);
  end

  for (genvar k = 0; k < SEQ_STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      i2cbm_step #(
        .DELAY_WIDTH  (DELAY_WIDTH),
        .TIMEOUT_WIDTH(TIMEOUT_WIDTH)
      ) u_step (
        .seq_in   (seq_init),
        .dly_in   (dly_init),
        .tmo_in   (tmo_r),
        .ht       (ht),
        .rf       (rf),
        .tmo_start(tmo_start),
        .tmo_byte (tmo_byte),
        .tmo_bit  (tmo_bit),
        .tmo_ack  (tmo_ack),
        .scl_in   (in_word.scl_in),
        .sda_in   (in_word.sda_in),
        .seq_out  (seq_s[k]),
        .dly_out  (dly_s[k]),
        .tmo_out  (tmo_s[k])
      );
    end else begin : g_next
      i2cbm_step #(
        .DELAY_WIDTH  (DELAY_WIDTH),
        .TIMEOUT_WIDTH(TIMEOUT_WIDTH)
      ) u_step (
        .seq_in   (seq_s[k-1]),
        .dly_in   (dly_s[k-1]),
        .tmo_in   (tmo_s[k-1]),
        .ht       (ht),
        .rf       (rf),
        .tmo_start(tmo_start),
        .tmo_byte (tmo_byte),
        .tmo_bit  (tmo_bit),
        .tmo_ack  (tmo_ack),
        .scl_in   (in_word.scl_in),
        .sda_in   (in_word.sda_in),
        .seq_out  (seq_s[k]),
        .dly_out  (dly_s[k]),
        .tmo_out  (tmo_s[k])
      );
    end
  end

  assign seq_nxt = seq_s[SEQ_STEPS-1];
  assign dly_nxt = dly_s[SEQ_STEPS-1];
  assign tmo_nxt = tmo_s[SEQ_STEPS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= SEQ_RESET;
      dly_r <= '0;
      tmo_r <= '0;
    end else if (tick_en) begin
      seq_r <= seq_nxt;
      dly_r <= dly_nxt;
      tmo_r <= tmo_nxt;
    end
  end

  assign res.scl_out   = seq_nxt.scl_drive;
  assign res.sda_out   = seq_nxt.sda_drive;
  assign res.busy_res  = (seq_nxt.phase != PH_IDLE);
  assign res.done_res  = seq_nxt.done_pulse;
  assign res.status    = seq_nxt.last_status;
  assign res.read_data = seq_nxt.rd_byte;

endmodule

@@ rtl/i2cbm_obuf.sv @@
// Result register with a skid stage for the I2C bit-level master.
// Depends on i2cbm_pkg.
module i2cbm_obuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  i2cbm_pkg::out_word_t push_word,
  output logic                 push_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cbm_pkg::out_word_t out_data
);
  import i2cbm_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_word_t out_data_r, out_data_nxt;
  out_word_t skid_data_r, skid_data_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        // Drain the skid word; no push is taken while it is full
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_word;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

endmodule

@@ rtl/i2c_bit_level_master.sv @@
// I2C bit-level bus master, top level. Uses i2cbm_pkg, i2cbm_cfg,
// i2cbm_core (with i2cbm_step) and i2cbm_obuf.
//
// Each input word is one time-base tick: an action code, command operands
// and the sampled SCL and SDA levels. Each accepted word yields exactly one
// result word: SCL and SDA drive levels, busy, a one-tick done pulse, the
// status of the last finished command and the last byte read.
// Commands (start, stop, write byte, read byte, address) are taken only
// while the sequencer is idle at the start of the tick; otherwise the word
// is just a tick.
// Throughput: one word per clock while in_ready is high. An accepted word's
// result is registered in the output register, or in the skid stage when the
// output stalls. The per-tick path chains up to four sequencer steps combinationally.
// When the receiver stalls, the result waits in the output register and
// one more word is taken into a skid stage; in_ready then drops until the
// output drains.
// Reset (rst_n low at a clock edge) returns the sequencer to idle with both
// lines released, clears counters and status, and loads the default timing
// registers. The cfg_ port writes one register per cycle with cfg_wr_en.
module i2c_bit_level_master #(
  parameter int DELAY_WIDTH   = i2cbm_pkg::DELAY_WIDTH_DEF,
  parameter int TIMEOUT_WIDTH = i2cbm_pkg::TIMEOUT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  i2cbm_pkg::in_word_t                in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output i2cbm_pkg::out_word_t               out_data,
  input  logic                               cfg_wr_en,
  input  logic [i2cbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [i2cbm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import i2cbm_pkg::*;

  cfg_t      cfg;
  out_word_t core_res;
  logic      in_fire;

  // Advance the sequencer only on an accepted word
  assign in_fire = in_valid && in_ready;

  i2cbm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  i2cbm_core #(
    .DELAY_WIDTH  (DELAY_WIDTH),
    .TIMEOUT_WIDTH(TIMEOUT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .tick_en(in_fire),
    .in_word(in_data),
    .cfg    (cfg),
    .res    (core_res)
  );

  // Hold the result until taken; park one more word in the skid stage
  i2cbm_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_word (core_res),
    .push_ready(in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The output is valid in the cycle after every accepted word
  a_word_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid)
    else $error("accepted word did not reach the output register");

  // A finishing tick always leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    core_res.done_res |-> !core_res.busy_res)
    else $error("done pulse while sequencer still busy");

  // A word taken during an output stall fills the skid stage and blocks input
  a_skid_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && in_fire) |=> !in_ready)
    else $error("input not blocked with skid stage occupied");

endmodule

@@ dv/i2c_bit_level_master_test.sv @@
// Self-checking testbench for i2c_bit_level_master: tick words in, line drive words out.
// Needs only i2cbm_pkg and the RTL; carries its own per-tick model of the sequencer.
module i2c_bit_level_master_test;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cbm_pkg::*;

  // Action codes the block treats as a plain tick
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  localparam int STALL_LIMIT = 2000;   // cycles without any handshake
  localparam int LATENCY_PAD = 4;      // settle time after the last result word
  localparam int HOLD_OFF    = 60;     // long receiver stall, fills the skid stage
  localparam int MAX_REPORTS = 10;

  localparam out_word_t IDLE_OUT = '{1'b1, 1'b1, 1'b0, 1'b0, ST_OK, 8'h00};

  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t want;
  } plan_row_t;

  // Directed words. The idle rows come straight after reset; the command rows
  // run at fast timing with short timeouts. Each command row is offered again
  // and again until the command ends, so the same command also arrives while
  // busy and in the tick that finishes it.
  localparam int PLAN_LEN   = 21;
  localparam int PLAN_TYPED = 3;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{'{ACT_TICK,   8'h00, 1'b0, 16'h0000, 1'b1, 1'b1}, 1'b1, IDLE_OUT},
    '{'{ACT_SPARE6, 8'hFF, 1'b1, 16'hFFFF, 1'b0, 1'b0}, 1'b1, IDLE_OUT},
    '{'{ACT_SPARE7, 8'h5A, 1'b0, 16'h1234, 1'b1, 1'b0}, 1'b1, IDLE_OUT},
    '{'{ACT_START,  8'h00, 1'b0, 16'h0000, 1'b1, 1'b1}, 1'b0, IDLE_OUT},
    '{'{ACT_WRITE,  8'hFF, 1'b0, 16'h0000, 1'b1, 1'b0}, 1'b0, IDLE_OUT},
    '{'{ACT_WRITE,  8'h00, 1'b1, 16'hFFFF, 1'b1, 1'b1}, 1'b0, IDLE_OUT},
    '{'{ACT_READ,   8'h00, 1'b0, 16'h0000, 1'b1, 1'b1}, 1'b0, IDLE_OUT},
    '{'{ACT_READ,   8'hFF, 1'b1, 16'h0000, 1'b1, 1'b0}, 1'b0, IDLE_OUT},
    '{'{ACT_STOP,   8'h00, 1'b0, 16'h0000, 1'b1, 1'b1}, 1'b0, IDLE_OUT},
    '{'{ACT_ADDR,   8'h00, 1'b0, 16'h0078, 1'b1, 1'b0}, 1'b0, IDLE_OUT},
    '{'{ACT_ADDR,   8'h00, 1'b0, 16'hA5F0, 1'b1, 1'b0}, 1'b0, IDLE_OUT},
    '{'{ACT_ADDR,   8'h00, 1'b0, 16'h12F7, 1'b1, 1'b0}, 1'b0, IDLE_OUT},
    '{'{ACT_ADDR,   8'h00, 1'b0, 16'h0000, 1'b1, 1'b0}, 1'b0, IDLE_OUT},
    '{'{ACT_ADDR,   8'h00, 1'b0, 16'hFF01, 1'b1, 1'b0}, 1'b0, IDLE_OUT},
    '{'{ACT_ADDR,   8'h00, 1'b0, 16'hFFFF, 1'b1, 1'b1}, 1'b0, IDLE_OUT},
    '{'{ACT_STOP,   8'h00, 1'b0, 16'h0000, 1'b1, 1'b1}, 1'b0, IDLE_OUT},
    '{'{ACT_START,  8'h00, 1'b0, 16'h0000, 1'b0, 1'b1}, 1'b0, IDLE_OUT},
    '{'{ACT_ADDR,   8'h00, 1'b0, 16'h00F0, 1'b0, 1'b0}, 1'b0, IDLE_OUT},
    '{'{ACT_WRITE,  8'hA5, 1'b0, 16'h0000, 1'b0, 1'b0}, 1'b0, IDLE_OUT},
    '{'{ACT_READ,   8'h00, 1'b1, 16'h0000, 1'b0, 1'b1}, 1'b0, IDLE_OUT},
    '{'{ACT_TICK,   8'h00, 1'b0, 16'h0000, 1'b1, 1'b1}, 1'b0, IDLE_OUT}
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;
  logic cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  i2c_bit_level_master u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer model: timing registers and state, advanced once per tick word
  // ---------------------------------------------------------------------------
  logic [9:0]  hold_reg, rise_reg;
  logic [15:0] bit_tmo_reg, byte_tmo_reg, ack_tmo_reg, start_tmo_reg;

  phase_t      seq_phase, raise_back, bit_back;
  act_t        cmd_kind;
  logic [3:0]  bits_done;
  int unsigned delay_left, stretch_left;
  logic [7:0]  tx_byte, rx_byte;
  logic [15:0] addr_word;
  logic        scl_drv, sda_drv, raise_good, second_addr, nack_after_read;
  logic        done_now, parked;
  logic [1:0]  stat_last, pend_stat;

  // Line levels and status the block must show, oldest first
  out_word_t line_status_q [$];

  int mismatches = 0;
  int checked = 0;
  int ticks_sent = 0;
  int cmds_started = 0;
  int settings_used = 1;
  int ends_by_status [4] = '{0, 0, 0, 0};
  int burst_left = 0;
  int hold_asks = 0;

  task automatic reset_model();
    hold_reg = CFG_RESET.hold_time;
    rise_reg = CFG_RESET.rise_fall_time;
    bit_tmo_reg = CFG_RESET.bit_timeout;
    byte_tmo_reg = CFG_RESET.byte_timeout;
    ack_tmo_reg = CFG_RESET.ack_timeout;
    start_tmo_reg = CFG_RESET.start_timeout;
    seq_phase = PH_IDLE;
    raise_back = PH_IDLE;
    bit_back = PH_IDLE;
    cmd_kind = ACT_TICK;
    bits_done = '0;
    delay_left = 0;
    stretch_left = 0;
    tx_byte = '0;
    rx_byte = '0;
    addr_word = '0;
    scl_drv = 1'b1;
    sda_drv = 1'b1;
    raise_good = 1'b0;
    second_addr = 1'b0;
    nack_after_read = 1'b0;
    done_now = 1'b0;
    parked = 1'b0;
    stat_last = ST_OK;
    pend_stat = ST_OK;
  endtask

  task automatic end_command(input logic [1:0] st);
    seq_phase = PH_IDLE;
    stat_last = st;
    done_now = 1'b1;
    parked = 1'b1;
    ends_by_status[st]++;
  endtask

  task automatic park(input phase_t nxt, input int unsigned d);
    seq_phase = nxt;
    delay_left = d;
    parked = 1'b1;
  endtask

  // A byte of a command has ended; address commands may chain a second byte
  // or fall back to a stop condition on failure.
  task automatic byte_outcome(input logic [1:0] st);
    if (cmd_kind != ACT_ADDR) begin
      end_command(st);
    end else if (st != ST_OK) begin
      pend_stat = st;
      seq_phase = PH_T_BEGIN;
    end else if (!second_addr) begin
      if ((addr_word[7:0] & ADDR_TEN_MASK) != ADDR_TEN_PREFIX &&
          (addr_word[7:0] & ADDR_GC_MASK) != ADDR_GC_PREFIX) begin
        end_command(ST_OK);
      end else begin
        second_addr = 1'b1;
        tx_byte = addr_word[15:8];
        seq_phase = PH_B_BEGIN;
      end
    end else begin
      end_command(ST_OK);
    end
  endtask

  task automatic seq_step(input logic scl_i, input logic sda_i);
    int unsigned ht, rf;
    ht = (hold_reg == '0) ? 1 : hold_reg;
    rf = (rise_reg == '0) ? 1 : rise_reg;
    case (seq_phase)
      PH_S_BEGIN: begin
        sda_drv = 1'b1;
        stretch_left = start_tmo_reg;
        raise_back = PH_S_AFTER;
        seq_phase = PH_RAISE_SET;
      end
      PH_S_AFTER: begin
        if (!raise_good) begin
          end_command(ST_TIMEOUT);
        end else begin
          sda_drv = 1'b0;
          park(PH_S_LOW, ht);
        end
      end
      PH_S_LOW: begin
        scl_drv = 1'b0;
        sda_drv = 1'b0;
        park(PH_S_END, ht);
      end
      PH_S_END: begin
        if (cmd_kind != ACT_ADDR) begin
          end_command(ST_OK);
        end else begin
          second_addr = 1'b0;
          tx_byte = addr_word[7:0];
          seq_phase = PH_B_BEGIN;
        end
      end
      PH_T_BEGIN: begin
        scl_drv = 1'b0;
        sda_drv = 1'b0;
        park(PH_T_2, rf);
      end
      PH_T_2: begin
        scl_drv = 1'b1;
        park(PH_T_3, ht);
      end
      PH_T_3: begin
        sda_drv = 1'b1;
        park(PH_T_END, ht);
      end
      PH_T_END: end_command(pend_stat);
      PH_W_BEGIN: begin
        scl_drv = 1'b0;
        raise_back = PH_W_AFTER;
        park(PH_RAISE_SET, rf);
      end
      PH_W_AFTER: park(PH_W_LOW, ht);
      PH_W_LOW: begin
        scl_drv = 1'b0;
        park(bit_back, ht);
      end
      PH_RAISE_SET: begin
        scl_drv = 1'b1;
        park(PH_RAISE_POLL, rf);
      end
      PH_RAISE_POLL: begin
        if (stretch_left == 0) begin
          raise_good = 1'b0;
          seq_phase = raise_back;
        end else if (scl_i) begin
          raise_good = 1'b1;
          seq_phase = raise_back;
        end else begin
          stretch_left = (stretch_left > rf) ? stretch_left - rf : 0;
          park(PH_RAISE_POLL, rf);
        end
      end
      PH_B_BEGIN: begin
        bits_done = '0;
        sda_drv = tx_byte[7];
        stretch_left = byte_tmo_reg;
        bit_back = PH_B_BIT_DONE;
        seq_phase = PH_W_BEGIN;
      end
      PH_B_BIT_DONE: begin
        if (!raise_good) begin
          byte_outcome(ST_TIMEOUT);
        end else begin
          bits_done++;
          if (bits_done < 8) begin
            sda_drv = tx_byte[7 - bits_done];
            stretch_left = bit_tmo_reg;
            seq_phase = PH_W_BEGIN;
          end else begin
            scl_drv = 1'b0;
            sda_drv = 1'b1;
            park(PH_B_ACK_RAISE, rf);
          end
        end
      end
      PH_B_ACK_RAISE: begin
        stretch_left = ht;
        raise_back = PH_B_ACK_RAISED;
        seq_phase = PH_RAISE_SET;
      end
      PH_B_ACK_RAISED: begin
        if (!raise_good) begin
          pend_stat = ST_TIMEOUT;
          seq_phase = PH_B_ACK_END;
        end else begin
          stretch_left = ack_tmo_reg;
          seq_phase = PH_B_ACK_POLL;
        end
      end
      PH_B_ACK_POLL: begin
        if (stretch_left == 0) begin
          pend_stat = ST_NACK;
          seq_phase = PH_B_ACK_END;
        end else begin
          park(PH_B_ACK_SAMPLE, ht);
        end
      end
      PH_B_ACK_SAMPLE: begin
        if (!sda_i) begin
          pend_stat = ST_OK;
          seq_phase = PH_B_ACK_END;
        end else begin
          stretch_left = (stretch_left > ht) ? stretch_left - ht : 0;
          seq_phase = PH_B_ACK_POLL;
        end
      end
      PH_B_ACK_END: begin
        scl_drv = 1'b0;
        sda_drv = 1'b1;
        park(PH_B_DONE, ht);
      end
      PH_B_DONE: byte_outcome(pend_stat);
      PH_R_BEGIN: begin
        scl_drv = 1'b0;
        sda_drv = 1'b1;
        bits_done = '0;
        park(PH_R_BIT, rf);
      end
      PH_R_BIT: begin
        sda_drv = 1'b1;
        stretch_left = (bits_done == 0) ? byte_tmo_reg : bit_tmo_reg;
        raise_back = PH_R_RAISED;
        seq_phase = PH_RAISE_SET;
      end
      PH_R_RAISED: park(PH_R_SAMPLE, ht);
      PH_R_SAMPLE: begin
        if (raise_good) begin
          if (bits_done == 0) rx_byte = {sda_i, 7'b0};
          else rx_byte[7 - bits_done[2:0]] = sda_i;
        end
        scl_drv = 1'b0;
        sda_drv = 1'b1;
        park(PH_R_BIT_DONE, ht);
      end
      PH_R_BIT_DONE: begin
        if (!raise_good) begin
          end_command(ST_TIMEOUT);
        end else begin
          bits_done++;
          if (bits_done < 8) begin
            seq_phase = PH_R_BIT;
          end else begin
            sda_drv = nack_after_read;
            stretch_left = bit_tmo_reg;
            bit_back = PH_R_ACK_DONE;
            seq_phase = PH_W_BEGIN;
          end
        end
      end
      PH_R_ACK_DONE: end_command(raise_good ? ST_OK : ST_TIMEOUT);
      default: begin
        seq_phase = PH_IDLE;
        parked = 1'b1;
      end
    endcase
  endtask

  // One tick: count down the pending wait, take a command if idle, then run
  // chained steps until the sequencer parks on a wait or goes idle.
  task automatic step_bus_master(input in_word_t w, output out_word_t r);
    int g;
    done_now = 1'b0;
    if (seq_phase != PH_IDLE && delay_left > 0) delay_left--;
    if (seq_phase == PH_IDLE && w.action >= ACT_START && w.action <= ACT_ADDR) begin
      cmd_kind = act_t'(w.action);
      pend_stat = ST_OK;
      delay_left = 0;
      tx_byte = w.data_byte;
      nack_after_read = w.final_read;
      addr_word = w.bus_address;
      cmds_started++;
      case (cmd_kind)
        ACT_START, ACT_ADDR: seq_phase = PH_S_BEGIN;
        ACT_STOP:            seq_phase = PH_T_BEGIN;
        ACT_WRITE:           seq_phase = PH_B_BEGIN;
        default:             seq_phase = PH_R_BEGIN;
      endcase
    end
    if (seq_phase != PH_IDLE && delay_left == 0) begin
      parked = 1'b0;
      for (g = 0; g < 64 && !parked; g++) seq_step(w.scl_in, w.sda_in);
    end
    r = '{scl_drv, sda_drv, seq_phase != PH_IDLE, done_now, stat_last, rx_byte};
  endtask

  // ---------------------------------------------------------------------------
  // Clock, receiver, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: rotate through stall patterns by bits 8:7 of its cycle counter;
  // on request, hold off completely for a long stretch so the block backs up.
  initial begin
    int unsigned rcv_cycle;
    int hold_served;
    int hold_left;
    rcv_cycle = 0;
    hold_served = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      rcv_cycle++;
      if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rcv_cycle[8:7])
          2'd0:    out_ready <= 1'b1;
          2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
          2'd2:    out_ready <= ((rcv_cycle % 5) != 0);
          default: out_ready <= 1'($urandom);
        endcase
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles, %0d result words outstanding",
                 quiet, line_status_q.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic flag_field(input string fld, input int unsigned want_v,
                            input int unsigned got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("word %0d: %s expected %0h got %0h", checked, fld, want_v, got_v);
  endtask

  // Sample at the falling edge: nothing moves between here and the rising
  // edge where the handshake completes, and the expectation for any word
  // shown now was pushed at an earlier rising edge.
  always @(negedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (line_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result word %h arrived with nothing outstanding", out_data);
      end else begin
        want = line_status_q.pop_front();
        if (out_data.scl_out !== want.scl_out)
          flag_field("scl_out", want.scl_out, out_data.scl_out);
        if (out_data.sda_out !== want.sda_out)
          flag_field("sda_out", want.sda_out, out_data.sda_out);
        if (out_data.busy_res !== want.busy_res)
          flag_field("busy_res", want.busy_res, out_data.busy_res);
        if (out_data.done_res !== want.done_res)
          flag_field("done_res", want.done_res, out_data.done_res);
        if (out_data.status !== want.status)
          flag_field("status", want.status, out_data.status);
        if (out_data.read_data !== want.read_data)
          flag_field("read_data", want.read_data, out_data.read_data);
      end
      checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one tick word; bursts of random length with random gaps between.
  // Valid stays high across a burst, so it is never dropped and raised in
  // the same step.
  task automatic offer_word(input in_word_t w, input logic typed, input out_word_t want);
    out_word_t next_lines;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    step_bus_master(w, next_lines);
    line_status_q.push_back(typed ? want : next_lines);
    ticks_sent++;
  endtask

  // Drop valid and hold until every result word is back, then let the
  // output pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (line_status_q.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  // Tick with released SCL until the running command ends.
  task automatic settle_idle();
    in_word_t w;
    while (seq_phase != PH_IDLE) begin
      w = '{ACT_TICK, 8'h00, 1'b0, 16'h0000, 1'b1, 1'($urandom)};
      offer_word(w, 1'b0, IDLE_OUT);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_IDX_HOLD:      hold_reg = val[9:0];
      CFG_IDX_RISE_FALL: rise_reg = val[9:0];
      CFG_IDX_BIT_TMO:   bit_tmo_reg = val;
      CFG_IDX_BYTE_TMO:  byte_tmo_reg = val;
      CFG_IDX_ACK_TMO:   ack_tmo_reg = val;
      CFG_IDX_START_TMO: start_tmo_reg = val;
      default: ;
    endcase
  endtask

  // Bring the block to rest, then load a full set of timing registers.
  task automatic retime(input logic [15:0] ht, input logic [15:0] rf,
                        input logic [15:0] bt, input logic [15:0] yt,
                        input logic [15:0] at, input logic [15:0] st);
    settle_idle();
    wait_drained();
    write_reg(CFG_IDX_HOLD, ht);
    write_reg(CFG_IDX_RISE_FALL, rf);
    write_reg(CFG_IDX_BIT_TMO, bt);
    write_reg(CFG_IDX_BYTE_TMO, yt);
    write_reg(CFG_IDX_ACK_TMO, at);
    write_reg(CFG_IDX_START_TMO, st);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Random traffic: mostly a command when idle followed by ticks until it
  // ends, with stray commands and spare action codes mixed into the ticks.
  // Rough commands see SCL held low half the time to force stretch timeouts.
  task automatic run_traffic(input int n, input bit noisy);
    in_word_t w;
    bit rough;
    int pick;
    rough = noisy;
    for (int k = 0; k < n; k++) begin
      if (seq_phase == PH_IDLE) begin
        rough = noisy || ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 7);
        if (pick < 6) w.action = 3'($urandom_range(ACT_START, ACT_ADDR));
        else if (pick == 6) w.action = ACT_TICK;
        else w.action = $urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7;
      end else begin
        w.action = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : ACT_TICK;
      end
      w.data_byte = 8'($urandom);
      w.final_read = 1'($urandom);
      case ($urandom_range(0, 2))
        0:       w.bus_address = {8'($urandom), ADDR_TEN_PREFIX | 8'($urandom_range(0, 7))};
        1:       w.bus_address = {8'($urandom), ADDR_GC_PREFIX | 8'($urandom_range(0, 1))};
        default: w.bus_address = 16'($urandom);
      endcase
      w.scl_in = rough ? 1'($urandom) : ($urandom_range(0, 15) != 0);
      w.sda_in = 1'($urandom);
      offer_word(w, 1'b0, IDLE_OUT);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_IDX_HOLD;
    cfg_wdata <= '0;
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: idle rows right after reset, then the command rows at
    // the fastest timing with short timeouts to keep them brief
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (i == PLAN_TYPED) retime(16'd1, 16'd1, 16'd4, 16'd4, 16'd4, 16'd4);
      do offer_word(PLAN[i].word, PLAN[i].typed, PLAN[i].want);
      while (seq_phase != PH_IDLE);
    end

    // Back to the power-up timing values
    retime(16'(CFG_RESET.hold_time), 16'(CFG_RESET.rise_fall_time),
           CFG_RESET.bit_timeout, CFG_RESET.byte_timeout,
           CFG_RESET.ack_timeout, CFG_RESET.start_timeout);
    run_traffic(100, 1'b0);

    // Fastest legal timing, short timeouts; stall the receiver long once and
    // pause the sender until everything is back once.
    retime(16'd1, 16'd1, 16'd3, 16'd4, 16'd2, 16'd3);
    hold_asks <= hold_asks + 1;
    run_traffic(200, 1'b0);
    wait_drained();
    run_traffic(60, 1'b1);

    // Zero hold and rise time (upper data bits dropped), every timeout zero
    retime(16'hFC00, 16'h0400, 16'd0, 16'd0, 16'd0, 16'd0);
    run_traffic(100, 1'b0);

    // Random timeouts across the full range
    retime(16'hFC03, 16'd2, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_traffic(120, 1'b0);

    // Slower edges with the longest timeouts
    retime(16'd4, 16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(40, 1'b0);

    // Tight timeouts at short delays
    retime(16'd2, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    run_traffic(100, 1'b0);

    settle_idle();
    wait_drained();
    if (line_status_q.size() != 0) begin
      mismatches++;
      $display("%0d result words never arrived", line_status_q.size());
    end

    $display("Checked %0d result words for %0d tick words over %0d timing settings.",
             checked, ticks_sent, settings_used);
    $display("Commands started %0d; ended ok %0d, stretch timeout %0d, no ack %0d.",
             cmds_started, ends_by_status[ST_OK], ends_by_status[ST_TIMEOUT],
             ends_by_status[ST_NACK]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
